### rtl/sstf_pkg.sv
package sstf_pkg;

    // Fixed field widths of the request and result beats.
    localparam int SECTOR_BITS = 48;
    localparam int LENGTH_BITS = 16;
    localparam int TAG_BITS    = 8;
    localparam int SUM_BITS    = 64;
    localparam int QCOUNT_BITS = 5;

    // Operation carried by a request beat.
    typedef enum logic
    {
        OP_ADD      = 1'b0,
        OP_DISPATCH = 1'b1
    } opcode_t;

    // Outcome reported in a result beat.
    typedef enum logic [1:0]
    {
        STATUS_ADDED      = 2'd0,
        STATUS_DISPATCHED = 2'd1,
        STATUS_EMPTY      = 2'd2,
        STATUS_FULL       = 2'd3
    } status_t;

    // One request beat.
    typedef struct packed
    {
        opcode_t                opcode;
        logic [SECTOR_BITS-1:0] request_sector;
        logic [LENGTH_BITS-1:0] request_length;
        logic [TAG_BITS-1:0]    request_tag;
    } request_t;

    // One result beat.
    typedef struct packed
    {
        status_t                status;
        logic [SECTOR_BITS-1:0] out_sector;
        logic [LENGTH_BITS-1:0] out_length;
        logic [TAG_BITS-1:0]    out_tag;
        logic [SECTOR_BITS-1:0] seek_distance;
        logic [SUM_BITS-1:0]    seek_total;
        logic [QCOUNT_BITS-1:0] queued_count;
    } result_t;

    // One stored request in the table.
    typedef struct packed
    {
        logic [SECTOR_BITS-1:0] sector;
        logic [LENGTH_BITS-1:0] length;
        logic [TAG_BITS-1:0]    tag;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed
    {
        logic    add;
        logic    reject;
        status_t reject_status;
        logic    scan_clear;
        logic    scan_rd;
        logic    finish;
        logic    shift_rd;
    } dp_cmd_t;

    // Table status from the datapath to the controller.
    typedef struct packed
    {
        logic full;
        logic empty;
    } dp_status_t;

endpackage

### rtl/sstf_datapath.sv
module sstf_datapath #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sstf_pkg::dp_cmd_t                 cmd,
    input  logic [$clog2(QUEUE_DEPTH)-1:0]    rd_addr,
    input  sstf_pkg::request_t                request,
    output sstf_pkg::dp_status_t              status,
    output logic [$clog2(QUEUE_DEPTH)-1:0]    last_idx,
    output logic [$clog2(QUEUE_DEPTH)-1:0]    best_idx,
    output sstf_pkg::result_t                 result
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Request table, kept in arrival order from slot zero upward.
    sstf_pkg::entry_t mem [QUEUE_DEPTH];

    logic [CNT_W-1:0]                     count_reg;
    logic [sstf_pkg::SECTOR_BITS-1:0]     head_reg;
    logic [sstf_pkg::SUM_BITS-1:0]        sum_reg;

    // Read stage.
    sstf_pkg::entry_t                     rd_entry_reg;
    logic [IDX_W-1:0]                     rd_idx_reg;
    logic                                 scan_vld_reg;
    logic                                 shift_vld_reg;

    // Distance stage.
    sstf_pkg::entry_t                     cand_entry_reg;
    logic [IDX_W-1:0]                     cand_idx_reg;
    logic [sstf_pkg::SECTOR_BITS-1:0]     dist_reg;
    logic                                 dist_vld_reg;

    // Best candidate so far.
    sstf_pkg::entry_t                     best_entry_reg;
    logic [IDX_W-1:0]                     best_idx_reg;
    logic [sstf_pkg::SECTOR_BITS-1:0]     best_dist_reg;
    logic                                 best_vld_reg;

    sstf_pkg::result_t                    result_reg;
    sstf_pkg::entry_t                     new_entry;
    logic [sstf_pkg::SECTOR_BITS-1:0]     gap;
    logic                                 better;

    assign new_entry.sector = request.request_sector;
    assign new_entry.length = request.request_length;
    assign new_entry.tag    = request.request_tag;

    // Absolute distance from the head to the sector just read.
    assign gap = (rd_entry_reg.sector >= head_reg) ? (rd_entry_reg.sector - head_reg)
                                                   : (head_reg - rd_entry_reg.sector);

    // A later slot wins ties, so the comparison includes equality.
    assign better = dist_vld_reg && (!best_vld_reg || (dist_reg <= best_dist_reg));

    assign status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign last_idx     = IDX_W'(count_reg - 1'b1);
    assign best_idx     = best_idx_reg;
    assign result       = result_reg;

    // Table memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.add)
        begin
            mem[IDX_W'(count_reg)] <= new_entry;
        end
        else if (shift_vld_reg)
        begin
            mem[rd_idx_reg - 1'b1] <= rd_entry_reg;
        end
        rd_entry_reg <= mem[rd_addr];
        rd_idx_reg   <= rd_addr;
    end

    // Control state: occupancy, head, running total and stage valids.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            head_reg      <= '0;
            sum_reg       <= '0;
            scan_vld_reg  <= 1'b0;
            shift_vld_reg <= 1'b0;
            dist_vld_reg  <= 1'b0;
            best_vld_reg  <= 1'b0;
        end
        else
        begin
            scan_vld_reg  <= cmd.scan_rd;
            shift_vld_reg <= cmd.shift_rd;
            dist_vld_reg  <= scan_vld_reg;
            if (cmd.scan_clear)
            begin
                best_vld_reg <= 1'b0;
            end
            else if (better)
            begin
                best_vld_reg <= 1'b1;
            end
            if (cmd.add)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (cmd.finish)
            begin
                count_reg <= count_reg - 1'b1;
                sum_reg   <= sum_reg + sstf_pkg::SUM_BITS'(best_dist_reg);
                head_reg  <= best_entry_reg.sector
                             + sstf_pkg::SECTOR_BITS'(best_entry_reg.length);
            end
        end
    end

    // Distance and best-candidate payload, and the result beat.
    always_ff @(posedge clk)
    begin
        cand_entry_reg <= rd_entry_reg;
        cand_idx_reg   <= rd_idx_reg;
        dist_reg       <= gap;
        if (better)
        begin
            best_entry_reg <= cand_entry_reg;
            best_idx_reg   <= cand_idx_reg;
            best_dist_reg  <= dist_reg;
        end
        if (cmd.add)
        begin
            result_reg.status        <= sstf_pkg::STATUS_ADDED;
            result_reg.out_sector    <= '0;
            result_reg.out_length    <= '0;
            result_reg.out_tag       <= '0;
            result_reg.seek_distance <= '0;
            result_reg.seek_total    <= sum_reg;
            result_reg.queued_count  <= sstf_pkg::QCOUNT_BITS'(count_reg + 1'b1);
        end
        else if (cmd.reject)
        begin
            result_reg.status        <= cmd.reject_status;
            result_reg.out_sector    <= '0;
            result_reg.out_length    <= '0;
            result_reg.out_tag       <= '0;
            result_reg.seek_distance <= '0;
            result_reg.seek_total    <= sum_reg;
            result_reg.queued_count  <= sstf_pkg::QCOUNT_BITS'(count_reg);
        end
        else if (cmd.finish)
        begin
            result_reg.status        <= sstf_pkg::STATUS_DISPATCHED;
            result_reg.out_sector    <= best_entry_reg.sector;
            result_reg.out_length    <= best_entry_reg.length;
            result_reg.out_tag       <= best_entry_reg.tag;
            result_reg.seek_distance <= best_dist_reg;
            result_reg.seek_total    <= sum_reg + sstf_pkg::SUM_BITS'(best_dist_reg);
            result_reg.queued_count  <= sstf_pkg::QCOUNT_BITS'(count_reg - 1'b1);
        end
    end

    // A request is never written into a full table.
    assert property (@(posedge clk) disable iff (!rst_n) cmd.add |-> !status.full)
        else $error("add written into a full table");

    // Removing the picked request lowers the occupancy by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("occupancy did not drop on dispatch");

    // The dispatch only finishes after at least one candidate was taken.
    assert property (@(posedge clk) disable iff (!rst_n) cmd.finish |-> best_vld_reg)
        else $error("dispatch finished without a candidate");

endmodule

### rtl/sstf_ctrl.sv
module sstf_ctrl #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  sstf_pkg::opcode_t                 opcode,
    input  sstf_pkg::dp_status_t              status,
    input  logic [$clog2(QUEUE_DEPTH)-1:0]    last_idx,
    input  logic [$clog2(QUEUE_DEPTH)-1:0]    best_idx,
    output sstf_pkg::dp_cmd_t                 cmd,
    output logic [$clog2(QUEUE_DEPTH)-1:0]    rd_addr,
    output logic                              busy,
    output logic                              done
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_SCAN,
        S_DRAIN1,
        S_DRAIN2,
        S_FINISH,
        S_SHIFT,
        S_SHIFT_DRAIN
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [IDX_W-1:0] lim_reg;
    logic [IDX_W-1:0] lim_next;
    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;

    assign rd_addr = idx_reg;
    assign busy    = busy_reg;
    assign done    = done_reg;

    // Sequencing of add, reject, scan and removal shift.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        lim_next   = lim_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (opcode == sstf_pkg::OP_DISPATCH)
                    begin
                        if (status.empty)
                        begin
                            cmd.reject        = 1'b1;
                            cmd.reject_status = sstf_pkg::STATUS_EMPTY;
                            done_next         = 1'b1;
                        end
                        else
                        begin
                            cmd.scan_clear = 1'b1;
                            idx_next       = '0;
                            lim_next       = last_idx;
                            busy_next      = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    else if (status.full)
                    begin
                        cmd.reject        = 1'b1;
                        cmd.reject_status = sstf_pkg::STATUS_FULL;
                        done_next         = 1'b1;
                    end
                    else
                    begin
                        cmd.add   = 1'b1;
                        done_next = 1'b1;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (idx_reg == lim_reg)
                begin
                    state_next = S_DRAIN1;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DRAIN1:
            begin
                state_next = S_DRAIN2;
            end
            S_DRAIN2:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                if (best_idx == lim_reg)
                begin
                    busy_next  = 1'b0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next   = best_idx + 1'b1;
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                cmd.shift_rd = 1'b1;
                if (idx_reg == lim_reg)
                begin
                    state_next = S_SHIFT_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_SHIFT_DRAIN:
            begin
                busy_next  = 1'b0;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                busy_next  = 1'b0;
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            lim_reg   <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            lim_reg   <= lim_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    // A result beat is only shown once the block is free again.
    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> !busy_reg)
        else $error("result strobe while busy");

    // The picked slot lies inside the occupied part of the table.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) |-> (best_idx <= lim_reg))
        else $error("picked slot beyond the table");

    // Busy is raised only while a dispatch is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !busy_reg)
        else $error("busy held while idle");

endmodule

### rtl/sstf_request_scheduler.sv
// Shortest-seek-first request scheduler.
// Request channel: a beat is taken at a rising edge with start high and busy low.
// Its opcode either adds a request (sector, length, tag) to the table tail or
// dispatches the stored request whose sector is nearest the head position; on
// equal distances the most recently added request is chosen.
// Result channel: done is high for exactly one cycle with the result beat; it is
// taken at the edge that ends that cycle and the receiver cannot hold it off.
// Adds, drops on a full table and dispatches on an empty table never raise busy;
// their result appears in the cycle after the request beat.
// A dispatch with n requests held, picking slot p, keeps busy high while the
// single-port table is scanned one slot a cycle through a read, distance and
// compare pipeline, and while the n-1-p younger slots move down one a cycle;
// when the youngest is picked, no slot moves and busy drops with the result.
// Reset empties the table and clears the head position and the seek total.
module sstf_request_scheduler #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  sstf_pkg::request_t request,
    output logic               busy,
    output logic               done,
    output sstf_pkg::result_t  result
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);

    sstf_pkg::dp_cmd_t    cmd;
    sstf_pkg::dp_status_t dp_status;
    logic [IDX_W-1:0]     rd_addr;
    logic [IDX_W-1:0]     last_idx;
    logic [IDX_W-1:0]     best_idx;

    // Controller sequencing each beat.
    sstf_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .opcode   (request.opcode),
        .status   (dp_status),
        .last_idx (last_idx),
        .best_idx (best_idx),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .busy     (busy),
        .done     (done)
    );

    // Table, distance pipeline and running totals.
    sstf_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .request  (request),
        .status   (dp_status),
        .last_idx (last_idx),
        .best_idx (best_idx),
        .result   (result)
    );

endmodule

### test/tb_top.sv
module tb_top;

    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 40;
    localparam int RANDOM_BEATS = 1900;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    sstf_pkg::request_t request = '0;
    logic               busy;
    logic               done;
    sstf_pkg::result_t  result;

    sstf_request_scheduler #(.QUEUE_DEPTH(DEPTH)) dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    // Free-running clock with a period of 10.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the scheduler state used to predict every result.
    sstf_pkg::entry_t slot_q [DEPTH];
    int unsigned      held = 0;
    logic [47:0]      head_pos = '0;
    logic [63:0]      seek_sum = '0;

    sstf_pkg::result_t pending_results [$];
    int          errors = 0;
    int          beats_sent = 0;
    int          cycles = 0;
    int          status_seen [4] = '{0, 0, 0, 0};
    int          tie_picks = 0;
    bit          allow_idle = 1'b1;

    // Applies one request beat to the shadow state and returns the result it causes.
    function automatic sstf_pkg::result_t next_result(input sstf_pkg::request_t req);
        sstf_pkg::result_t r;
        int unsigned pick;
        logic [63:0] best;
        logic [63:0] gap;
        r = '0;
        if (req.opcode == sstf_pkg::OP_ADD)
        begin
            if (held >= DEPTH)
                r.status = sstf_pkg::STATUS_FULL;
            else
            begin
                slot_q[held] = {req.request_sector, req.request_length, req.request_tag};
                held++;
                r.status = sstf_pkg::STATUS_ADDED;
            end
        end
        else if (held == 0)
            r.status = sstf_pkg::STATUS_EMPTY;
        else
        begin
            // Scan oldest first; a later slot at an equal distance takes over.
            pick = 0;
            best = '1;
            for (int i = 0; i < held; i++)
            begin
                gap = (slot_q[i].sector > head_pos) ? slot_q[i].sector - head_pos
                                                    : head_pos - slot_q[i].sector;
                if (gap == best)
                    tie_picks++;
                if (gap <= best)
                begin
                    best = gap;
                    pick = i;
                end
            end
            r.status        = sstf_pkg::STATUS_DISPATCHED;
            r.out_sector    = slot_q[pick].sector;
            r.out_length    = slot_q[pick].length;
            r.out_tag       = slot_q[pick].tag;
            r.seek_distance = best[47:0];
            seek_sum        = seek_sum + best;
            head_pos        = slot_q[pick].sector + slot_q[pick].length;
            // Younger entries move down one slot to keep arrival order.
            for (int i = pick; i + 1 < held; i++)
                slot_q[i] = slot_q[i + 1];
            held--;
        end
        r.seek_total   = seek_sum;
        r.queued_count = sstf_pkg::QCOUNT_BITS'(held);
        return r;
    endfunction

    function automatic logic [47:0] rand_sector();
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        return wide[47:0];
    endfunction

    // Sectors cluster around the head often enough to produce ties and short seeks.
    function automatic logic [47:0] pick_sector();
        logic [47:0] offset;
        int unsigned roll;
        roll   = $urandom_range(99);
        offset = 48'($urandom_range(3));
        if (roll < 25)
            return $urandom_range(1) ? head_pos + offset : head_pos - offset;
        else if (roll < 35)
            return $urandom_range(1) ? 48'h0 : '1;
        else if (roll < 45 && held > 0)
            return slot_q[$urandom_range(held - 1)].sector;
        else
            return rand_sector();
    endfunction

    function automatic logic [15:0] pick_length();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 20)
            return 16'h0000;
        else if (roll < 30)
            return 16'hFFFF;
        else
            return 16'($urandom_range(16'hFFFF));
    endfunction

    // Sends one beat, waits until it is taken and records the result it must cause.
    task automatic send_beat(input sstf_pkg::request_t req);
        request <= req;
        start   <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(next_result(req));
        beats_sent++;
    endtask

    // Random pause between beats, decided cycle by cycle; start drops only while pausing.
    task automatic maybe_idle();
        while (allow_idle && $urandom_range(99) < 23)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic add_request(input logic [47:0] sector, input logic [15:0] length,
                               input logic [7:0] tag);
        sstf_pkg::request_t req;
        req.opcode         = sstf_pkg::OP_ADD;
        req.request_sector = sector;
        req.request_length = length;
        req.request_tag    = tag;
        send_beat(req);
        maybe_idle();
    endtask

    // Dispatch beats carry random content in the fields the block ignores.
    task automatic dispatch_request();
        sstf_pkg::request_t req;
        req.opcode         = sstf_pkg::OP_DISPATCH;
        req.request_sector = rand_sector();
        req.request_length = 16'($urandom_range(16'hFFFF));
        req.request_tag    = 8'($urandom_range(8'hFF));
        send_beat(req);
        maybe_idle();
    endtask

    task automatic test_empty_dispatch();
        dispatch_request();
    endtask

    // The farthest sector with the longest length moves the head past the top.
    task automatic test_head_wrap();
        add_request('1, 16'hFFFF, 8'hFF);
        dispatch_request();
    endtask

    // Two requests equally far from the head: the later one must win.
    task automatic test_equal_distance();
        add_request(head_pos + 48'd3, 16'h0001, 8'h5A);
        add_request(head_pos - 48'd3, 16'h0000, 8'hA5);
        dispatch_request();
    endtask

    // Fill the table to the top, then one more add must be dropped.
    task automatic test_full_table();
        logic [47:0] sector;
        while (held < DEPTH)
        begin
            case (held % 3)
                0: sector = 48'h0;
                1: sector = '1;
                default: sector = rand_sector();
            endcase
            add_request(sector, (held % 2) ? 16'hFFFF : 16'h0000,
                        (held % 2) ? 8'hFF : 8'h00);
        end
        add_request(rand_sector(), 16'h1234, 8'h77);
        dispatch_request();
        dispatch_request();
    endtask

    // Long random traffic; the add bias shifts so the table fills and drains.
    task automatic test_random_traffic();
        int add_bias;
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            case ((n / 100) % 4)
                0: add_bias = 75;
                1: add_bias = 50;
                2: add_bias = 25;
                default: add_bias = 60;
            endcase
            allow_idle = !(n >= 700 && n < 1100);
            if ($urandom_range(99) < add_bias)
                add_request(pick_sector(), pick_length(), 8'($urandom_range(8'hFF)));
            else
                dispatch_request();
        end
        allow_idle = 1'b1;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endtask

    // Every result beat is compared with the oldest outstanding prediction.
    always @(posedge clk)
    begin : check_results
        sstf_pkg::result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result %h arrived with nothing expected", $time, result);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                status_seen[want.status]++;
                check_field("status", want.status, result.status);
                check_field("out_sector", want.out_sector, result.out_sector);
                check_field("out_length", want.out_length, result.out_length);
                check_field("out_tag", want.out_tag, result.out_tag);
                check_field("seek_distance", want.seek_distance, result.seek_distance);
                check_field("seek_total", want.seek_total, result.seek_total);
                check_field("queued_count", want.queued_count, result.queued_count);
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_dispatch();
        test_head_wrap();
        test_equal_distance();
        test_full_table();
        test_random_traffic();

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT)
            @(posedge clk);

        $display("Ran %0d request beats: %0d adds, %0d dispatches, %0d drops on a full table,",
                 beats_sent, status_seen[sstf_pkg::STATUS_ADDED],
                 status_seen[sstf_pkg::STATUS_DISPATCHED],
                 status_seen[sstf_pkg::STATUS_FULL]);
        $display("%0d dispatches on an empty table, %0d equal-distance picks, %0d errors.",
                 status_seen[sstf_pkg::STATUS_EMPTY], tie_picks, errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

### filelist.f
rtl/sstf_pkg.sv
rtl/sstf_datapath.sv
rtl/sstf_ctrl.sv
rtl/sstf_request_scheduler.sv
test/tb_top.sv
